[rtl/longest_distinct_byte_run_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the distinct-byte run block.
// ----------------------------------------------------------------------------
`ifndef LONGEST_DISTINCT_BYTE_RUN_MACROS_SVH
`define LONGEST_DISTINCT_BYTE_RUN_MACROS_SVH

// same-cycle implication
`define LDBR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LDBR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ldbr_pkg.sv]
// ----------------------------------------------------------------------------
// ldbr_pkg
// Fixed widths and constants of the distinct-byte run block.
// ----------------------------------------------------------------------------
package ldbr_pkg;

   localparam int BYTE_BITS   = 8;
   localparam int TABLE_DEPTH = 1 << BYTE_BITS;
   localparam int OUT_BITS    = 16;
   localparam int OUT_MAX     = (1 << OUT_BITS) - 1;

   typedef logic [BYTE_BITS-1:0] byte_type;
   typedef logic [OUT_BITS-1:0]  out_type;

endpackage

[rtl/ldbr_ram.sv]
// ----------------------------------------------------------------------------
// ldbr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ldbr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/longest_distinct_byte_run.sv]
// ----------------------------------------------------------------------------
// longest_distinct_byte_run
// Longest run of pairwise distinct bytes ending at each byte of a stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one byte per transfer; req_start_req marks the first
//   byte of a new string and clears the history before that byte is handled.
//   rsp_ channel returns one result per byte, in order: run length ending at
//   the byte, longest run so far in the string, and the sticky overflow flag.
//   Throughput: one byte per cycle while results are taken. The last-position
//   table is a 256-entry RAM with one read and one write port; the read is
//   issued at the input transfer and the write-back as the byte leaves the
//   lookup stage, with the most recent write forwarded so back-to-back repeats
//   of a byte are handled. A byte goes through the lookup and result registers.
//   Reset (synchronous, active high) clears the seen flags, window start,
//   position, best length and overflow flag at once; the first string begins
//   at reset. No clearing pass is needed.
//   When the receiver stalls, the result register holds and the input keeps
//   taking one more byte into the lookup stage, then req_ready drops.
// ----------------------------------------------------------------------------
`include "longest_distinct_byte_run_macros.svh"

module longest_distinct_byte_run #(
   parameter int POS_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  ldbr_pkg::byte_type             req_data_byte,
   input  logic                           req_start_req,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output ldbr_pkg::out_type              rsp_run_length,
   output ldbr_pkg::out_type              rsp_longest,
   output logic                           rsp_overflow
);

   localparam int RUN_BITS = POS_BITS + 1;
   localparam int EXT_BITS = (RUN_BITS > ldbr_pkg::OUT_BITS) ? RUN_BITS
                                                            : ldbr_pkg::OUT_BITS + 1;
   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
   localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
   localparam logic [RUN_BITS-1:0] RUN_ONE = RUN_BITS'(1);

   // lookup stage
   logic                       s1_valid_ff;
   ldbr_pkg::byte_type         s1_byte_ff;
   logic                       s1_start_ff;
   logic                       s1_adv;
   logic                       s1_fire;
   logic                       req_fire;

   // string state
   logic [ldbr_pkg::TABLE_DEPTH-1:0] seen_ff, seen_in;
   logic [POS_BITS-1:0]        window_start_ff, window_start_in;
   logic [POS_BITS-1:0]        position_ff, position_in;
   logic [RUN_BITS-1:0]        best_ff, best_in;
   logic                       ovf_ff, ovf_in;

   // forwarding of the latest table write
   logic                       fwd_valid_ff;
   ldbr_pkg::byte_type         fwd_byte_ff;
   logic [POS_BITS-1:0]        fwd_pos_ff;

   // result register
   logic                       rsp_valid_ff;
   ldbr_pkg::out_type          run_out_ff, run_out_in;
   ldbr_pkg::out_type          best_out_ff, best_out_in;
   logic                       ovf_out_ff;

   logic [POS_BITS-1:0]        ram_rd_data;
   logic [POS_BITS-1:0]        pos_cur, ws_cur, last_pos, ws_hit, ws_sel;
   logic [RUN_BITS-1:0]        best_cur, run;
   logic [POS_BITS:0]          next_start;
   logic                       full, seen_hit;
   logic [EXT_BITS-1:0]        run_ext, best_ext;

   assign s1_adv    = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && s1_adv;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;

   ldbr_ram #(
      .WIDTH (POS_BITS),
      .DEPTH (ldbr_pkg::TABLE_DEPTH)
   ) u_last_pos (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_byte_ff),
      .wr_data (pos_cur),
      .rd_en   (req_fire),
      .rd_addr (req_data_byte),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      pos_cur  = s1_start_ff ? '0 : position_ff;
      ws_cur   = s1_start_ff ? '0 : window_start_ff;
      best_cur = s1_start_ff ? '0 : best_ff;
      full     = (pos_cur == POS_MAX);
      ovf_in   = (s1_start_ff ? 1'b0 : ovf_ff) | full;

      last_pos = (fwd_valid_ff && (fwd_byte_ff == s1_byte_ff)) ? fwd_pos_ff : ram_rd_data;
      seen_hit = !s1_start_ff && seen_ff[s1_byte_ff] && (last_pos >= ws_cur);

      next_start = {1'b0, last_pos} + RUN_ONE;
      ws_hit     = (next_start > {1'b0, pos_cur}) ? pos_cur : next_start[POS_BITS-1:0];
      ws_sel     = seen_hit ? ws_hit : ws_cur;
      window_start_in = (ws_sel > pos_cur) ? pos_cur : ws_sel;

      run     = {1'b0, pos_cur} - {1'b0, window_start_in} + RUN_ONE;
      best_in = (run > best_cur) ? run : best_cur;

      position_in = full ? pos_cur : pos_cur + POS_ONE;

      seen_in = s1_start_ff ? '0 : seen_ff;
      seen_in[s1_byte_ff] = 1'b1;

      run_ext     = EXT_BITS'(run);
      best_ext    = EXT_BITS'(best_in);
      run_out_in  = (run_ext > EXT_BITS'(ldbr_pkg::OUT_MAX)) ? '1
                                                            : run_ext[ldbr_pkg::OUT_BITS-1:0];
      best_out_in = (best_ext > EXT_BITS'(ldbr_pkg::OUT_MAX)) ? '1
                                                             : best_ext[ldbr_pkg::OUT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         fwd_valid_ff    <= 1'b0;
         seen_ff         <= '0;
         window_start_ff <= '0;
         position_ff     <= '0;
         best_ff         <= '0;
         ovf_ff          <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s1_fire) begin
            rsp_valid_ff    <= 1'b1;
            fwd_valid_ff    <= 1'b1;
            seen_ff         <= seen_in;
            window_start_ff <= window_start_in;
            position_ff     <= position_in;
            best_ff         <= best_in;
            ovf_ff          <= ovf_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff  <= req_data_byte;
         s1_start_ff <= req_start_req;
      end
      if (s1_fire) begin
         fwd_byte_ff <= s1_byte_ff;
         fwd_pos_ff  <= pos_cur;
         run_out_ff  <= run_out_in;
         best_out_ff <= best_out_in;
         ovf_out_ff  <= ovf_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_run_length = run_out_ff;
   assign rsp_longest    = best_out_ff;
   assign rsp_overflow   = ovf_out_ff;

   `LDBR_ASSERT_NOW(a_run_nonzero, clock, reset, rsp_valid_ff, run_out_ff != '0, "run length zero")
   `LDBR_ASSERT_NOW(a_run_le_best, clock, reset, rsp_valid_ff,
                    run_out_ff <= best_out_ff, "run above best")
   `LDBR_ASSERT_NOW(a_stall_blocks, clock, reset, s1_valid_ff && !s1_adv,
                    !req_ready, "lookup overrun")
   `LDBR_ASSERT_NOW(a_ovf_pos_full, clock, reset, ovf_ff,
                    position_ff == POS_MAX, "overflow without full position")
   `LDBR_ASSERT_NOW(a_ws_le_pos, clock, reset, 1'b1,
                    window_start_ff <= position_ff, "window start past position")

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives byte strings into longest_distinct_byte_run and checks every result
// against a predictor that keeps its own last-position table, window start
// and position counter. Directed strings first, then random strings with
// random gaps on both sides and one long receiver hold-off, then a short
// restarted string.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int              POS_BITS     = 16;
   localparam longint unsigned POS_MAX      = (64'd1 << POS_BITS) - 1;
   localparam int              RANDOM_BYTES = 800;
   localparam int              HOLD_CYCLES  = 120;
   localparam int              HOLD_AFTER   = 200;
   localparam int              IDLE_LIMIT   = 2000;
   localparam int              DRAIN_CYCLES = 4;

   // string shapes
   localparam int KIND_PERM     = 0;
   localparam int KIND_RANDOM   = 1;
   localparam int KIND_NARROW   = 2;
   localparam int KIND_PERIODIC = 3;

   typedef struct packed {
      ldbr_pkg::out_type run_len;
      ldbr_pkg::out_type longest;
      logic              overflow;
   } run_result_type;

   class run_scoreboard_type;
      bit              seen[ldbr_pkg::TABLE_DEPTH];
      longint unsigned last_pos[ldbr_pkg::TABLE_DEPTH];
      longint unsigned win_start;
      longint unsigned next_pos;
      longint unsigned best;
      bit              ovf;
      run_result_type  expected_q[$];
      int              errors;
      int              checked;
      int              bytes_seen;
      int              strings;
      int              max_run;

      function new();
         clear_string();
         foreach (last_pos[i]) last_pos[i] = 0;
         errors = 0;
         checked = 0;
         bytes_seen = 0;
         strings = 1;
         max_run = 0;
      endfunction

      function void clear_string();
         foreach (seen[i]) seen[i] = 0;
         win_start = 0;
         next_pos = 0;
         best = 0;
         ovf = 0;
      endfunction

      function ldbr_pkg::out_type sat(longint unsigned v);
         return (v > ldbr_pkg::OUT_MAX) ? ldbr_pkg::out_type'(ldbr_pkg::OUT_MAX)
                                        : ldbr_pkg::out_type'(v);
      endfunction

      function void note_byte(ldbr_pkg::byte_type b, logic first);
         longint unsigned pos;
         longint unsigned run;
         run_result_type  r;
         if (first) begin
            clear_string();
            if (bytes_seen > 0) strings++;
         end
         pos = next_pos;
         if (pos >= POS_MAX) begin
            pos = POS_MAX;
            ovf = 1;
         end
         if (seen[b] && last_pos[b] >= win_start)
            win_start = (last_pos[b] + 1 > pos) ? pos : last_pos[b] + 1;
         if (win_start > pos) win_start = pos;
         run = pos - win_start + 1;
         if (run > best) best = run;
         if (run > max_run) max_run = int'(run);
         last_pos[b] = pos;
         seen[b] = 1;
         next_pos = (pos < POS_MAX) ? pos + 1 : POS_MAX;
         r.run_len = sat(run);
         r.longest = sat(best);
         r.overflow = ovf;
         expected_q.insert(expected_q.size(), r);
         bytes_seen++;
      endfunction

      function void check_result(ldbr_pkg::out_type run_len, ldbr_pkg::out_type lng,
                                 logic ovf_bit);
         run_result_type e;
         checked++;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, run_length %0d longest %0d overflow %0b",
                     $time, run_len, lng, ovf_bit);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (run_len !== e.run_len) begin
            $display("%0t: run_length expected %0d actual %0d", $time, e.run_len, run_len);
            errors++;
         end
         if (lng !== e.longest) begin
            $display("%0t: longest expected %0d actual %0d", $time, e.longest, lng);
            errors++;
         end
         if (ovf_bit !== e.overflow) begin
            $display("%0t: overflow expected %0b actual %0b", $time, e.overflow, ovf_bit);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   ldbr_pkg::byte_type req_data_byte;
   logic               req_start_req;
   logic               rsp_valid;
   logic               rsp_ready;
   ldbr_pkg::out_type  rsp_run_length;
   ldbr_pkg::out_type  rsp_longest;
   logic               rsp_overflow;

   run_scoreboard_type sb;
   bit                 idle_on;
   int                 idle_cycles;

   longest_distinct_byte_run #(
      .POS_BITS(POS_BITS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_start_req  (req_start_req),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_run_length (rsp_run_length),
      .rsp_longest    (rsp_longest),
      .rsp_overflow   (rsp_overflow)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial sb = new();

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && req_ready) sb.note_byte(req_data_byte, req_start_req);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_run_length, rsp_longest, rsp_overflow);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      @(posedge clock);
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // result side: random stalls, plus one long hold-off so the block backs up
   initial begin
      int stall;
      bit hold_done;
      hold_done = 0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!hold_done && sb.checked >= HOLD_AFTER) begin
            hold_done = 1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = idle_on ? $urandom_range(0, 4) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_byte(input ldbr_pkg::byte_type b, input logic first);
      int gap;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_start_req <= first;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_string(input int kind, input int len, input logic first);
      ldbr_pkg::byte_type perm[ldbr_pkg::TABLE_DEPTH];
      ldbr_pkg::byte_type tmp;
      int                 alpha;
      int                 period;
      ldbr_pkg::byte_type base;
      int                 j;
      alpha = 1 << $urandom_range(0, 4);
      period = $urandom_range(1, 256);
      base = ldbr_pkg::byte_type'($urandom_range(0, 255));
      foreach (perm[i]) perm[i] = ldbr_pkg::byte_type'(i);
      for (int i = ldbr_pkg::TABLE_DEPTH - 1; i > 0; i--) begin
         j = int'($urandom_range(0, i));
         tmp = perm[i];
         perm[i] = perm[j];
         perm[j] = tmp;
      end
      for (int i = 0; i < len; i++) begin
         ldbr_pkg::byte_type b;
         case (kind)
            KIND_PERM: begin
               b = (i < ldbr_pkg::TABLE_DEPTH) ? perm[i]
                                               : ldbr_pkg::byte_type'($urandom_range(0, 255));
            end
            KIND_RANDOM: begin
               b = ldbr_pkg::byte_type'($urandom_range(0, 255));
            end
            KIND_NARROW: begin
               b = base + ldbr_pkg::byte_type'($urandom_range(0, alpha - 1));
            end
            default: begin
               // periodic
               b = perm[i % period];
            end
         endcase
         send_byte(b, (i == 0) ? first : 1'b0);
      end
   endtask

   initial begin
      ldbr_pkg::byte_type directed_bytes[$];
      logic               directed_first[$];
      int                 sent;
      int                 draw;
      int                 kind;
      int                 len;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data_byte <= '0;
      req_start_req <= 1'b0;
      idle_on = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no start after reset, extremes, back-to-back repeats, stale entry
      // outside the window, one-byte strings
      directed_bytes = {8'h00, 8'hFF, 8'h55, 8'hAA, 8'hFF, 8'hFF, 8'hFF,
                        8'h61, 8'h62, 8'h62, 8'h61, 8'h63,
                        8'h00, 8'h00, 8'h01, 8'h80, 8'h00, 8'h7F, 8'h01};
      directed_first = {1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                        1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                        1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
      foreach (directed_bytes[i]) send_byte(directed_bytes[i], directed_first[i]);

      sent = 0;
      while (sent < RANDOM_BYTES) begin
         idle_on = ($urandom_range(0, 3) != 0);
         draw = $urandom_range(0, 9);
         if (draw == 0) begin
            kind = KIND_PERM;
            len = ldbr_pkg::TABLE_DEPTH + $urandom_range(0, 40);
         end else begin
            kind = (draw <= 3) ? KIND_RANDOM : (draw <= 7) ? KIND_NARROW : KIND_PERIODIC;
            len = $urandom_range(1, 80);
         end
         if (len > RANDOM_BYTES - sent) len = RANDOM_BYTES - sent;
         send_string(kind, len, ($urandom_range(0, 7) != 0));
         sent += len;
      end

      // restart after the random phase
      idle_on = 1;
      send_string(KIND_NARROW, 10, 1'b1);

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results over %0d bytes in %0d strings; longest run %0d.",
               sb.checked, sb.bytes_seen, sb.strings, sb.max_run);
      $display("Covered directed repeats, random strings with gaps and a long output stall.");
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
